// ----- hdl/bds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and constants for the byte delimiter splitter.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int unsigned ByteW = 8;

  // configuration register indexes
  localparam logic CfgDelimBytes  = 1'b0;
  localparam logic CfgDelimLength = 1'b1;

  // result word, first member in the highest bits
  typedef struct packed {
    logic             last_result;
    logic             part_end;
    logic             has_byte;
    logic [ByteW-1:0] data_out;
  } bds_result_t;

  // per-cell window control
  typedef struct packed {
    logic wr_en;
    logic shift_en;
    logic active;
  } bds_cell_ctrl_t;

endpackage : bds_pkg
`default_nettype wire

// ----- hdl/byte_delimiter_splitter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each result word is registered in the two-word output buffer on its way out.
// Throughput: one input word per cycle while the output buffer has room and
// no flush runs; the compare runs across the cell row. After a word with tlast,
// the waiting window bytes and the closing part end leave one per cycle, while
// the output buffer has room, with input held off. Reset clears the delimiter
// registers, the fill count, the flush state and the two-word output buffer.
// ----------------------------------------------------------------------------
// byte_delimiter_splitter
// Splits a byte stream into parts at a configured multi-byte delimiter.
// ----------------------------------------------------------------------------
module byte_delimiter_splitter
  import bds_pkg::*;
#(
  parameter int unsigned MAX_DELIMITER_BYTES = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [ByteW-1:0] s_axis_tdata,   // [7:0] data_in
  input  wire logic             s_axis_tlast,   // string_end
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [ByteW-1:0] m_axis_tdata,   // [7:0] data_out
  output logic      [1:0]       m_axis_tuser,   // [0] has_byte, [1] part_end
  output logic                  m_axis_tlast,   // last_result
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [63:0]      cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_DELIMITER_BYTES + 1);

  logic [63:0]     delim_q;
  logic [3:0]      len_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ne_q, ne_d;
  logic            flush_q, flush_d;

  logic [CntW-1:0] eff_len, cnt_w, cnt_inc;
  logic            accept, push, wr_step, shift_en, fifo_wr_ready, win_match;
  bds_result_t     res, out_res;

  logic [ByteW-1:0] eff_byte [MAX_DELIMITER_BYTES];
  logic             match_chain [MAX_DELIMITER_BYTES+1];

  assign eff_len = (len_q > 4'(MAX_DELIMITER_BYTES)) ? CntW'(MAX_DELIMITER_BYTES)
                                                     : len_q[CntW-1:0];
  assign cnt_w   = (cnt_q >= eff_len) ? '0 : cnt_q;
  assign cnt_inc = cnt_w + CntW'(1);

  assign s_axis_tready = !flush_q && fifo_wr_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // window cell row
  assign match_chain[0] = 1'b1;
  for (genvar i = 0; i < MAX_DELIMITER_BYTES; i++) begin : g_cell
    bds_cell_ctrl_t   ctrl;
    logic [ByteW-1:0] nbr;

    assign ctrl.wr_en    = wr_step && (cnt_w == CntW'(i));
    assign ctrl.shift_en = shift_en;
    assign ctrl.active   = (CntW'(i) < eff_len);

    if (i == MAX_DELIMITER_BYTES - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_body
      assign nbr = eff_byte[i+1];
    end

    bds_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .wr_byte_i    (s_axis_tdata),
      .nbr_byte_i   (nbr),
      .delim_byte_i (delim_q[ByteW*i +: ByteW]),
      .match_i      (match_chain[i]),
      .eff_byte_o   (eff_byte[i]),
      .match_o      (match_chain[i+1])
    );
  end
  assign win_match = match_chain[MAX_DELIMITER_BYTES];

  always_comb begin
    push     = 1'b0;
    res      = '0;
    shift_en = 1'b0;
    wr_step  = 1'b0;
    cnt_d    = cnt_q;
    ne_d     = ne_q;
    flush_d  = flush_q;
    if (accept) begin
      if (eff_len == '0) begin
        push            = 1'b1;
        res.data_out    = s_axis_tdata;
        res.has_byte    = 1'b1;
        res.part_end    = 1'b1;
        res.last_result = 1'b1;
        cnt_d           = '0;
        ne_d            = 1'b0;
      end else begin
        wr_step = 1'b1;
        cnt_d   = cnt_inc;
        if (cnt_inc == eff_len) begin
          push            = 1'b1;
          res.last_result = 1'b1;
          if (win_match) begin
            res.part_end = 1'b1;
            cnt_d        = '0;
            ne_d         = 1'b0;
          end else begin
            res.data_out = eff_byte[0];
            res.has_byte = 1'b1;
            shift_en     = 1'b1;
            cnt_d        = cnt_w;
            ne_d         = 1'b1;
          end
        end
        if (s_axis_tlast) begin
          if ((cnt_d != '0) || ne_d) begin
            flush_d         = 1'b1;
            res.last_result = 1'b0;
          end else begin
            res.last_result = 1'b1;
          end
        end
      end
    end else if (flush_q && fifo_wr_ready) begin
      push = 1'b1;
      if (cnt_q != '0) begin
        res.data_out = eff_byte[0];
        res.has_byte = 1'b1;
        shift_en     = 1'b1;
        cnt_d        = cnt_q - CntW'(1);
        ne_d         = 1'b1;
      end else begin
        res.part_end    = 1'b1;
        res.last_result = 1'b1;
        ne_d            = 1'b0;
        flush_d         = 1'b0;
      end
    end
    // drop waiting bytes on a length write
    if (cfg_we_i && (cfg_idx_i == CfgDelimLength)) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      ne_q    <= 1'b0;
      flush_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      ne_q    <= ne_d;
      flush_q <= flush_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgDelimBytes:  delim_q <= cfg_data_i;
          CfgDelimLength: len_q   <= cfg_data_i[3:0];
          default:        ;
        endcase
      end
    end
  end

  bds_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .wr_ready_o  (fifo_wr_ready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_res),
    .ready_i     (m_axis_tready)
  );

  assign m_axis_tdata = out_res.data_out;
  assign m_axis_tuser = {out_res.part_end, out_res.has_byte};
  assign m_axis_tlast = out_res.last_result;

`ifndef SYNTHESIS
  a_flush_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> !s_axis_tready)
    else $error("input accepted during flush");

  a_cnt_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) || (cnt_q < eff_len))
    else $error("window count reached delimiter length");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> fifo_wr_ready)
    else $error("result pushed into full buffer");

  a_flush_close_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_q && (cnt_q == '0)) |-> ne_q)
    else $error("flush closing an empty part");

  a_flush_ends_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(flush_q) |-> $past(push && res.last_result))
    else $error("flush left without a last result");
`endif

endmodule : byte_delimiter_splitter
`default_nettype wire

// ----- hdl/bds_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_cell
// One window cell: holds a byte, takes a new byte or its neighbour's byte,
// and extends the delimiter compare chain.
// ----------------------------------------------------------------------------
module bds_cell
  import bds_pkg::*;
(
  input  wire logic             clk_i,
  input  wire bds_cell_ctrl_t   ctrl_i,
  input  wire logic [ByteW-1:0] wr_byte_i,
  input  wire logic [ByteW-1:0] nbr_byte_i,
  input  wire logic [ByteW-1:0] delim_byte_i,
  input  wire logic             match_i,
  output logic      [ByteW-1:0] eff_byte_o,
  output logic                  match_o
);

  logic [ByteW-1:0] byte_q, byte_d;

  assign eff_byte_o = ctrl_i.wr_en ? wr_byte_i : byte_q;
  assign match_o    = match_i && (!ctrl_i.active || (eff_byte_o == delim_byte_i));
  assign byte_d     = ctrl_i.shift_en ? nbr_byte_i : eff_byte_o;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule : bds_cell
`default_nettype wire

// ----- hdl/bds_out_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_out_fifo
// Two-word result buffer between the splitter core and the output stream.
// ----------------------------------------------------------------------------
module bds_out_fifo
  import bds_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire bds_result_t push_data_i,
  output logic             wr_ready_o,
  output logic             valid_o,
  output bds_result_t      data_o,
  input  wire logic        ready_i
);

  localparam logic [1:0] Depth = 2'd2;

  bds_result_t mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        pop, push;

  assign wr_ready_o = (cnt_q != Depth);
  assign valid_o    = (cnt_q != 2'd0);
  assign data_o     = mem_q[rd_ptr_q];
  assign pop        = valid_o && ready_i;
  assign push       = push_i && wr_ready_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule : bds_out_fifo
`default_nettype wire
